/* hdl/fdmd_pkg.sv */
// Shared constants, types and helpers of the frame difference motion detector.
`default_nettype none

package fdmd_pkg;

    // Pixel and brightness widths
    localparam int CH_W  = 8;
    localparam int SUM_W = 10;

    // Frame sampling and brightness store
    localparam int MAX_SAMPLES   = 131072;
    localparam int SAMPLE_STRIDE = 4;
    localparam int COUNT_W       = 18;
    localparam int ADDR_W        = $clog2(MAX_SAMPLES);
    localparam int PHASE_W       = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;

    // Brightness is (r+g+b)/3, done as a multiply by 683/2048 (exact below 768)
    localparam int DIV3_MUL = 683;
    localparam int DIV3_SH  = 11;

    // Percentage arithmetic
    localparam int PCT_W  = 14;
    localparam int NUM_W  = 32;
    localparam int SCALE  = 10000;
    localparam int STEP_W = $clog2(PCT_W);

    // Frame result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_THRESH       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_HUNDREDTHS = 1'd1;
    localparam logic [CH_W-1:0]      LUMA_THRESH_RST       = 8'd25;
    localparam logic [PCT_W-1:0]     MOTION_HUNDREDTHS_RST = 14'd200;

    typedef enum logic [1:0] {
        ST_COMPARED = 2'd0,
        ST_NEW_REF  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // One frame summary from the front end
    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   changed;
        logic [COUNT_W-1:0]   checked;
    } frame_result_t;

    // Queue fill state seen by both sides
    typedef struct packed {
        logic empty;
        logic has_room;
    } queue_state_t;

    function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [SUM_W+DIV3_SH-1:0] p;
        p = (SUM_W + DIV3_SH)'(x) * (SUM_W + DIV3_SH)'(DIV3_MUL);
        return p[DIV3_SH +: CH_W];
    endfunction

endpackage

`default_nettype wire

/* hdl/fdmd_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module fdmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the old contents on a same-address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/fdmd_front.sv */
// Front end: pixel transfer, sampling, brightness store access and frame summary.
`default_nettype none

module fdmd_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [fdmd_pkg::CH_W-1:0]      s_red,
    input  wire logic [fdmd_pkg::CH_W-1:0]      s_green,
    input  wire logic [fdmd_pkg::CH_W-1:0]      s_blue,
    input  wire logic                           s_last_of_frame,
    input  wire logic [fdmd_pkg::CH_W-1:0]      luma_thresh,
    input  wire fdmd_pkg::queue_state_t         q_state,
    output logic                                push,
    output fdmd_pkg::frame_result_t             push_data
);

    import fdmd_pkg::*;

    logic                 accept;
    logic [SUM_W-1:0]     sum;
    logic [CH_W-1:0]      bright;
    logic                 is_sample;
    logic                 in_room;
    logic                 store;
    logic                 ovf_after;
    logic [COUNT_W-1:0]   cnt_after;
    logic [CH_W-1:0]      old_bright;
    logic [CH_W-1:0]      diff;
    logic                 hit;
    logic [COUNT_W-1:0]   changed_sum;

    logic [PHASE_W-1:0]   phase_reg,     phase_next;
    logic [COUNT_W-1:0]   sample_cnt_reg, sample_cnt_next;
    logic [COUNT_W-1:0]   ref_cnt_reg,   ref_cnt_next;
    logic                 ref_valid_reg, ref_valid_next;
    logic                 ovf_reg,       ovf_next;
    logic [COUNT_W-1:0]   changed_reg,   changed_next;

    logic                 s1_valid_reg,  s1_valid_next;
    logic                 s1_cmp_reg,    s1_cmp_next;
    logic                 s1_last_reg,   s1_last_next;
    logic [CH_W-1:0]      s1_bright_reg, s1_bright_next;
    status_t              s1_status_reg, s1_status_next;
    logic [COUNT_W-1:0]   s1_checked_reg, s1_checked_next;

    // Hold off pixels while the result queue could overflow
    assign s_ready = q_state.has_room;
    assign accept  = s_valid && s_ready;

    assign sum    = SUM_W'(s_red) + SUM_W'(s_green) + SUM_W'(s_blue);
    assign bright = div3(sum);

    // Classify the pixel
    assign is_sample = !ovf_reg && (phase_reg == '0);
    assign in_room   = sample_cnt_reg < COUNT_W'(MAX_SAMPLES);
    assign store     = accept && is_sample && in_room;
    assign ovf_after = ovf_reg || (is_sample && !in_room);
    assign cnt_after = store ? sample_cnt_reg + COUNT_W'(1) : sample_cnt_reg;

    fdmd_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store),
        .wr_addr (sample_cnt_reg[ADDR_W-1:0]),
        .wr_data (bright),
        .rd_en   (store),
        .rd_addr (sample_cnt_reg[ADDR_W-1:0]),
        .rd_data (old_bright)
    );

    // Advance frame counters and decide the frame status on the last pixel
    always_comb begin
        phase_next      = phase_reg;
        sample_cnt_next = sample_cnt_reg;
        ref_cnt_next    = ref_cnt_reg;
        ref_valid_next  = ref_valid_reg;
        ovf_next        = ovf_reg;
        s1_valid_next   = accept;
        s1_cmp_next     = store && ref_valid_reg && (sample_cnt_reg < ref_cnt_reg);
        s1_last_next    = accept && s_last_of_frame;
        s1_bright_next  = bright;
        s1_status_next  = ST_COMPARED;
        s1_checked_next = cnt_after;
        if (accept) begin
            ovf_next        = ovf_after;
            sample_cnt_next = cnt_after;
            if (!ovf_after) begin
                phase_next = (phase_reg == PHASE_W'(SAMPLE_STRIDE - 1)) ?
                             '0 : phase_reg + PHASE_W'(1);
            end
            if (s_last_of_frame) begin
                if (ovf_after) begin
                    s1_status_next = ST_OVERFLOW;
                    ref_valid_next = 1'b0;
                    ref_cnt_next   = '0;
                end else if (!ref_valid_reg || (cnt_after != ref_cnt_reg)) begin
                    s1_status_next = ST_NEW_REF;
                    ref_valid_next = 1'b1;
                    ref_cnt_next   = cnt_after;
                end
                phase_next      = '0;
                sample_cnt_next = '0;
                ovf_next        = 1'b0;
            end
        end
    end

    // Compare against the stored brightness in the cycle after the read
    assign diff        = (old_bright > s1_bright_reg) ? old_bright - s1_bright_reg
                                                      : s1_bright_reg - old_bright;
    assign hit         = s1_valid_reg && s1_cmp_reg && (diff > luma_thresh);
    assign changed_sum = changed_reg + COUNT_W'(hit);

    assign push              = s1_valid_reg && s1_last_reg;
    assign push_data.status  = s1_status_reg;
    assign push_data.changed = changed_sum;
    assign push_data.checked = s1_checked_reg;

    always_comb begin
        changed_next = changed_reg;
        if (s1_valid_reg) begin
            changed_next = s1_last_reg ? '0 : changed_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            sample_cnt_reg <= '0;
            ref_cnt_reg    <= '0;
            ref_valid_reg  <= 1'b0;
            ovf_reg        <= 1'b0;
            changed_reg    <= '0;
            s1_valid_reg   <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            sample_cnt_reg <= sample_cnt_next;
            ref_cnt_reg    <= ref_cnt_next;
            ref_valid_reg  <= ref_valid_next;
            ovf_reg        <= ovf_next;
            changed_reg    <= changed_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        s1_cmp_reg     <= s1_cmp_next;
        s1_last_reg    <= s1_last_next;
        s1_bright_reg  <= s1_bright_next;
        s1_status_reg  <= s1_status_next;
        s1_checked_reg <= s1_checked_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_cnt_reg <= COUNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_changed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> push_data.changed <= push_data.checked)
        else $error("changed samples exceed checked samples");

endmodule

`default_nettype wire

/* hdl/fdmd_queue.sv */
// Small queue of frame summaries between front end and back end.
`default_nettype none

module fdmd_queue (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire fdmd_pkg::frame_result_t push_data,
    input  wire logic                    pop,
    output fdmd_pkg::frame_result_t      pop_data,
    output fdmd_pkg::queue_state_t       q_state
);

    import fdmd_pkg::*;

    frame_result_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg,    cnt_next;

    assign pop_data = mem_reg[rd_ptr_reg];

    // One slot is kept spare for the summary still in flight in the front end
    assign q_state.empty    = (cnt_reg == '0);
    assign q_state.has_room = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> cnt_reg < QCNT_W'(QUEUE_DEPTH))
        else $error("frame summary written into a full queue");

    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != '0)
        else $error("frame summary read from an empty queue");

endmodule

`default_nettype wire

/* hdl/fdmd_back.sv */
// Back end: percentage division, motion decision and result output register.
`default_nettype none

module fdmd_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [fdmd_pkg::PCT_W-1:0]   motion_hundredths,
    input  wire fdmd_pkg::queue_state_t       q_state,
    input  wire fdmd_pkg::frame_result_t      pop_data,
    output logic                              pop,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_status,
    output logic [fdmd_pkg::COUNT_W-1:0]      m_changed_count,
    output logic [fdmd_pkg::COUNT_W-1:0]      m_checked_count,
    output logic [fdmd_pkg::PCT_W-1:0]        m_percent_hundredths,
    output logic                              m_motion
);

    import fdmd_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_DIV  = 4'b0100,
        B_OUT  = 4'b1000
    } back_state_t;

    back_state_t          state_reg,   state_next;
    status_t              status_reg,  status_next;
    logic [COUNT_W-1:0]   changed_reg, changed_next;
    logic [COUNT_W-1:0]   checked_reg, checked_next;
    logic [PCT_W-1:0]     quot_reg,    quot_next;
    logic                 motion_reg,  motion_next;
    logic [NUM_W-1:0]     rem_reg,     rem_next;
    logic [NUM_W-1:0]     div_reg,     div_next;
    logic [NUM_W-1:0]     thr_reg,     thr_next;
    logic [STEP_W-1:0]    step_reg,    step_next;

    // Take a summary, scale, then divide one quotient bit per cycle
    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        changed_next = changed_reg;
        checked_next = checked_reg;
        quot_next    = quot_reg;
        motion_next  = motion_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        thr_next     = thr_reg;
        step_next    = step_reg;
        pop          = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_state.empty) begin
                    pop         = 1'b1;
                    status_next = pop_data.status;
                    quot_next   = '0;
                    motion_next = 1'b0;
                    if (pop_data.status == ST_COMPARED) begin
                        changed_next = pop_data.changed;
                        checked_next = pop_data.checked;
                        state_next   = (pop_data.checked != '0) ? B_MUL : B_OUT;
                    end else begin
                        changed_next = '0;
                        checked_next = '0;
                        state_next   = B_OUT;
                    end
                end
            end
            B_MUL: begin
                rem_next   = NUM_W'(changed_reg) * NUM_W'(SCALE);
                thr_next   = NUM_W'(motion_hundredths) * NUM_W'(checked_reg);
                div_next   = NUM_W'({checked_reg, {(PCT_W - 1){1'b0}}});
                step_next  = STEP_W'(PCT_W - 1);
                state_next = B_DIV;
            end
            B_DIV: begin
                if (step_reg == STEP_W'(PCT_W - 1)) begin
                    motion_next = rem_reg > thr_reg;
                end
                if (rem_reg >= div_reg) begin
                    rem_next  = rem_reg - div_reg;
                    quot_next = {quot_reg[PCT_W-2:0], 1'b1};
                end else begin
                    quot_next = {quot_reg[PCT_W-2:0], 1'b0};
                end
                div_next = div_reg >> 1;
                if (step_reg == '0) begin
                    state_next = B_OUT;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            B_OUT: begin
                if (m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        changed_reg <= changed_next;
        checked_reg <= checked_next;
        quot_reg    <= quot_next;
        motion_reg  <= motion_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        thr_reg     <= thr_next;
        step_reg    <= step_next;
    end

    assign m_valid              = (state_reg == B_OUT);
    assign m_status             = status_reg;
    assign m_changed_count      = changed_reg;
    assign m_checked_count      = checked_reg;
    assign m_percent_hundredths = quot_reg;
    assign m_motion             = motion_reg;

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_COMPARED)) |->
            (m_changed_count == '0 && m_checked_count == '0 &&
             m_percent_hundredths == '0 && !m_motion))
        else $error("uncompared frame reports nonzero fields");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_percent_hundredths <= PCT_W'(SCALE))
        else $error("percentage above full scale");

endmodule

`default_nettype wire

/* hdl/frame_difference_motion_detector.sv */
// Top level of the frame difference motion detector: configuration and wiring.
`default_nettype none

// Takes one RGB pixel per clock in raster order, with s_last_of_frame on the
// final pixel, and emits one result per frame after its last pixel. Every
// fourth pixel of a frame is a sample; its brightness (r+g+b)/3 is compared
// with the same sample of the previous frame held in a 131072 x 8 block RAM,
// and the new brightness is written back in the same cycle. Pixels are taken
// at one per clock; s_ready falls once three frame results wait in the queue
// for the back end. A compared frame occupies the back end while it takes
// the summary, does a multiply step, a 14-bit bit-serial division and an
// output step, plus any output stall; a new-reference or overflow frame only
// takes the summary and outputs it. The store needs no clearing after reset:
// an entry's old brightness is only compared once the previous frame has
// written it.
module frame_difference_motion_detector (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [fdmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fdmd_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [fdmd_pkg::CH_W-1:0]        s_red,
    input  wire logic [fdmd_pkg::CH_W-1:0]        s_green,
    input  wire logic [fdmd_pkg::CH_W-1:0]        s_blue,
    input  wire logic                             s_last_of_frame,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic [fdmd_pkg::COUNT_W-1:0]          m_changed_count,
    output logic [fdmd_pkg::COUNT_W-1:0]          m_checked_count,
    output logic [fdmd_pkg::PCT_W-1:0]            m_percent_hundredths,
    output logic                                  m_motion
);

    import fdmd_pkg::*;

    logic [CH_W-1:0]   pix_thr_reg,  pix_thr_next;
    logic [PCT_W-1:0]  motion_thr_reg, motion_thr_next;

    logic              push;
    logic              pop;
    frame_result_t     push_data;
    frame_result_t     pop_data;
    queue_state_t      q_state;

    // Decode configuration writes
    always_comb begin
        pix_thr_next    = pix_thr_reg;
        motion_thr_next = motion_thr_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LUMA_THRESH:       pix_thr_next    = cfg_wdata[CH_W-1:0];
                CFG_MOTION_HUNDREDTHS: motion_thr_next = cfg_wdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_thr_reg    <= LUMA_THRESH_RST;
            motion_thr_reg <= MOTION_HUNDREDTHS_RST;
        end else begin
            pix_thr_reg    <= pix_thr_next;
            motion_thr_reg <= motion_thr_next;
        end
    end

    fdmd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .s_last_of_frame (s_last_of_frame),
        .luma_thresh     (pix_thr_reg),
        .q_state         (q_state),
        .push            (push),
        .push_data       (push_data)
    );

    fdmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_state   (q_state)
    );

    fdmd_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .motion_hundredths    (motion_thr_reg),
        .q_state              (q_state),
        .pop_data             (pop_data),
        .pop                  (pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_changed_count      (m_changed_count),
        .m_checked_count      (m_checked_count),
        .m_percent_hundredths (m_percent_hundredths),
        .m_motion             (m_motion)
    );

endmodule

`default_nettype wire

/* verif/tb_frame_difference_motion_detector.sv */
// Testbench for the frame difference motion detector: directed frames and random scenes.
`default_nettype none

module tb_frame_difference_motion_detector;
    import fdmd_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PIXELS  = 225;
    localparam int SCENE_MAX     = 64;
    localparam int SETTLE_CYCLES = 40;

    // One frame result as the ports present it
    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] changed;
        logic [COUNT_W-1:0] checked;
        logic [PCT_W-1:0]   pct;
        logic               motion;
    } frame_summary_t;

    // One row of the directed pixel script
    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic            last;
        logic            typed;
        frame_summary_t  want;
    } script_row_t;

    localparam frame_summary_t NONE    = '0;
    localparam frame_summary_t NEW_REF = '{ST_NEW_REF, 18'd0, 18'd0, 14'd0, 1'b0};
    localparam frame_summary_t ALL_MOVED = '{ST_COMPARED, 18'd2, 18'd2, 14'd10000, 1'b1};

    // First frame, full change, short frames, threshold edges, longer frame than reference
    localparam script_row_t PIXEL_SCRIPT [22] = '{
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NONE},
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, NONE},
        '{8'd128, 8'd64,  8'd32,  1'b0, 1'b0, NONE},
        '{8'd1,   8'd2,   8'd3,   1'b0, 1'b0, NONE},
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, NEW_REF},
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, NONE},
        '{8'd255, 8'd0,   8'd255, 1'b0, 1'b0, NONE},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, NONE},
        '{8'd170, 8'd85,  8'd170, 1'b0, 1'b0, NONE},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, ALL_MOVED},
        '{8'd9,   8'd9,   8'd9,   1'b1, 1'b1, NEW_REF},
        '{8'd34,  8'd35,  8'd36,  1'b1, 1'b0, NONE},
        '{8'd60,  8'd60,  8'd60,  1'b0, 1'b0, NONE},
        '{8'd15,  8'd240, 8'd15,  1'b0, 1'b0, NONE},
        '{8'd240, 8'd15,  8'd240, 1'b0, 1'b0, NONE},
        '{8'd77,  8'd78,  8'd79,  1'b0, 1'b0, NONE},
        '{8'd200, 8'd201, 8'd202, 1'b1, 1'b1, NEW_REF},
        '{8'd85,  8'd85,  8'd85,  1'b0, 1'b0, NONE},
        '{8'd255, 8'd255, 8'd0,   1'b0, 1'b0, NONE},
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, NONE},
        '{8'd3,   8'd3,   8'd3,   1'b0, 1'b0, NONE},
        '{8'd175, 8'd175, 8'd174, 1'b1, 1'b0, NONE}
    };

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = CFG_LUMA_THRESH;
    logic [CFG_W-1:0]     cfg_wdata       = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [CH_W-1:0]      s_red           = '0;
    logic [CH_W-1:0]      s_green         = '0;
    logic [CH_W-1:0]      s_blue          = '0;
    logic                 s_last_of_frame = 1'b0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [1:0]           m_status;
    logic [COUNT_W-1:0]   m_changed_count;
    logic [COUNT_W-1:0]   m_checked_count;
    logic [PCT_W-1:0]     m_percent_hundredths;
    logic                 m_motion;

    frame_difference_motion_detector dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_red                (s_red),
        .s_green              (s_green),
        .s_blue               (s_blue),
        .s_last_of_frame      (s_last_of_frame),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_changed_count      (m_changed_count),
        .m_checked_count      (m_checked_count),
        .m_percent_hundredths (m_percent_hundredths),
        .m_motion             (m_motion)
    );

    // Motion model state
    logic [CH_W-1:0]    luma_ref [MAX_SAMPLES];
    logic [19:0]        pix_pos;
    logic [COUNT_W-1:0] samples_seen;
    logic [COUNT_W-1:0] ref_samples;
    logic [COUNT_W-1:0] changed_run;
    logic               ref_ok;
    logic               store_full;
    logic [CH_W-1:0]    thresh_cfg;
    logic [PCT_W-1:0]   motion_cfg;

    frame_summary_t expected_frames [$];
    int unsigned    mismatches  = 0;
    int unsigned    cycle_count = 0;
    int unsigned    sent_pixels = 0;
    bit             pace_on     = 1'b1;

    // Scene held between frames so that most samples change only a little
    logic [CH_W-1:0] scene_r [SCENE_MAX];
    logic [CH_W-1:0] scene_g [SCENE_MAX];
    logic [CH_W-1:0] scene_b [SCENE_MAX];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("frame_difference_motion_detector test failed");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the motion model by one pixel; report a frame result on the last pixel
    task automatic track_pixel(input logic [CH_W-1:0] r, g, b, input logic last,
                               output logic got, output frame_summary_t res);
        logic [SUM_W-1:0] sum;
        logic [CH_W-1:0]  luma;
        logic [CH_W-1:0]  prior;
        logic [CH_W-1:0]  diff;
        logic [63:0]      scaled;
        sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
        luma = CH_W'(sum / 3);
        got  = 1'b0;
        res  = NONE;
        if (!store_full) begin
            if (pix_pos % SAMPLE_STRIDE == 0) begin
                if (samples_seen < MAX_SAMPLES) begin
                    if (ref_ok && samples_seen < ref_samples) begin
                        prior = luma_ref[samples_seen];
                        diff  = (prior > luma) ? prior - luma : luma - prior;
                        if (diff > thresh_cfg)
                            changed_run = changed_run + 1'b1;
                    end
                    luma_ref[samples_seen] = luma;
                    samples_seen = samples_seen + 1'b1;
                end else begin
                    store_full = 1'b1;
                end
            end
            if (!store_full)
                pix_pos = pix_pos + 1'b1;
        end
        if (last) begin
            got = 1'b1;
            if (store_full) begin
                res.status  = ST_OVERFLOW;
                ref_ok      = 1'b0;
                ref_samples = '0;
            end else if (!ref_ok || samples_seen != ref_samples) begin
                res.status  = ST_NEW_REF;
                ref_ok      = 1'b1;
                ref_samples = samples_seen;
            end else begin
                res.status  = ST_COMPARED;
                res.changed = changed_run;
                res.checked = samples_seen;
                if (samples_seen != 0) begin
                    scaled     = 64'(changed_run) * 64'(SCALE);
                    res.pct    = PCT_W'(scaled / 64'(samples_seen));
                    res.motion = scaled > 64'(motion_cfg) * 64'(samples_seen);
                end
            end
            pix_pos      = '0;
            samples_seen = '0;
            changed_run  = '0;
            store_full   = 1'b0;
        end
    endtask

    // Offer one pixel, hold it until the transfer, then predict its effect
    task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input logic last,
                              input logic typed, input frame_summary_t want);
        int unsigned    gap;
        logic           got;
        frame_summary_t res;
        gap = pace_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_red           <= r;
        s_green         <= g;
        s_blue          <= b;
        s_last_of_frame <= last;
        do @(posedge aclk); while (!s_ready);
        track_pixel(r, g, b, last, got, res);
        if (got)
            expected_frames.push_back(typed ? want : res);
        sent_pixels++;
        @(negedge aclk);
    endtask

    // Stop offering, wait for every frame result, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write both registers on consecutive cycles; the block is idle here
    task automatic configure(input logic [CH_W-1:0] thresh, input logic [PCT_W-1:0] hundredths);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LUMA_THRESH;
        cfg_wdata <= CFG_W'(thresh);
        @(negedge aclk);
        cfg_index <= CFG_MOTION_HUNDREDTHS;
        cfg_wdata <= CFG_W'(hundredths);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        thresh_cfg = thresh;
        motion_cfg = hundredths;
    endtask

    // Play one frame of the scene: replace some pixels, jitter the rest
    task automatic play_frame(input int unsigned len, input int unsigned churn);
        for (int p = 0; p < len; p++) begin
            if ($urandom_range(0, 99) < churn) begin
                scene_r[p] = $urandom_range(0, 255);
                scene_g[p] = $urandom_range(0, 255);
                scene_b[p] = $urandom_range(0, 255);
            end else begin
                scene_r[p] = scene_r[p] ^ CH_W'($urandom_range(0, 7));
                scene_g[p] = scene_g[p] ^ CH_W'($urandom_range(0, 7));
                scene_b[p] = scene_b[p] ^ CH_W'($urandom_range(0, 7));
            end
            send_pixel(scene_r[p], scene_g[p], scene_b[p], p == len - 1, 1'b0, NONE);
        end
    endtask

    function automatic int unsigned field_differs(input string name, input logic [31:0] want,
                                                  input logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        return 1;
    endfunction

    // Result sink: ready with random stalls
    initial begin : result_sink
        int unsigned hold;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (pace_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                hold = 1 + pick_gap();
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Check each result transfer against the oldest expected frame
    always @(posedge aclk) begin
        frame_summary_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected frame result, expected none actual status %0d",
                         $time, m_status);
                mismatches++;
            end else begin
                want = expected_frames.pop_front();
                mismatches += field_differs("status", 32'(want.status), 32'(m_status));
                mismatches += field_differs("changed_count", 32'(want.changed),
                                            32'(m_changed_count));
                mismatches += field_differs("checked_count", 32'(want.checked),
                                            32'(m_checked_count));
                mismatches += field_differs("percent_hundredths", 32'(want.pct),
                                            32'(m_percent_hundredths));
                mismatches += field_differs("motion", 32'(want.motion), 32'(m_motion));
            end
        end
    end

    initial begin : stimulus
        int unsigned frame_len;
        int unsigned churn;
        int unsigned phase_end;
        pix_pos      = '0;
        samples_seen = '0;
        ref_samples  = '0;
        changed_run  = '0;
        ref_ok       = 1'b0;
        store_full   = 1'b0;
        thresh_cfg   = LUMA_THRESH_RST;
        motion_cfg   = MOTION_HUNDREDTHS_RST;
        for (int i = 0; i < SCENE_MAX; i++) begin
            scene_r[i] = $urandom_range(0, 255);
            scene_g[i] = $urandom_range(0, 255);
            scene_b[i] = $urandom_range(0, 255);
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames under the reset thresholds
        foreach (PIXEL_SCRIPT[i])
            send_pixel(PIXEL_SCRIPT[i].r, PIXEL_SCRIPT[i].g, PIXEL_SCRIPT[i].b,
                       PIXEL_SCRIPT[i].last, PIXEL_SCRIPT[i].typed, PIXEL_SCRIPT[i].want);
        drain();

        // Random scenes, one register setting per phase
        frame_len = 8;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: configure(8'd0, 14'd0);
                1: configure(8'd255, 14'd10000);
                2: configure(8'd25, 14'd16383);
                default: configure(CH_W'($urandom_range(0, 40)),
                                   PCT_W'($urandom_range(0, 10000)));
            endcase
            phase_end = sent_pixels + PHASE_PIXELS;
            while (sent_pixels < phase_end) begin
                // Change the frame size now and then: count mismatch
                if ($urandom_range(0, 5) == 0)
                    frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, SCENE_MAX)
                                                            : $urandom_range(1, 16);
                churn   = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(0, 20);
                pace_on = ($urandom_range(0, 3) != 0);
                play_frame(frame_len, churn);
            end
            pace_on = 1'b1;
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("frame_difference_motion_detector test passed");
        else
            $display("frame_difference_motion_detector test failed");
        $finish;
    end

endmodule

`default_nettype wire
